// ===== rtl/glfo_pkg.sv =====
// Shared codes and constants of the gated LFO modulator.
// Holds the quarter-wave sine entry function used to build the ROM.
// No dependencies.
package glfo_pkg;

	// Default parameter values.
	localparam int PHASE_BITS_DEF       = 24;
	localparam int SINE_TABLE_DEPTH_DEF = 256;
	localparam int NOTE_COUNT_DEF       = 128;

	// Register indexes of the configuration port.
	localparam logic [2:0] REG_WAVE_SHAPE   = 3'd0;
	localparam logic [2:0] REG_RATE_CENTIHZ = 3'd1;
	localparam logic [2:0] REG_DEPTH_LEVEL  = 3'd2;
	localparam logic [2:0] REG_OFFSET_LEVEL = 3'd3;
	localparam logic [2:0] REG_BIPOLAR_MODE = 3'd4;
	localparam logic [2:0] REG_RETRIGGER    = 3'd5;
	localparam logic [2:0] REG_OUTPUT_EN    = 3'd6;
	localparam logic [2:0] REG_SRATE_HZ     = 3'd7;

	localparam int CFG_DATA_W = 18;

	// Wave shapes.
	localparam logic [1:0] SHAPE_SIN = 2'd0;
	localparam logic [1:0] SHAPE_TRI = 2'd1;
	localparam logic [1:0] SHAPE_SQR = 2'd2;
	localparam logic [1:0] SHAPE_SAW = 2'd3;

	// Result kinds.
	localparam logic [1:0] KIND_MIDI  = 2'd0;
	localparam logic [1:0] KIND_VALUE = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	// MIDI codes.
	localparam logic [7:0] MIDI_START   = 8'hFA;
	localparam logic [7:0] MIDI_STOP    = 8'hFC;
	localparam logic [3:0] MIDI_NOTE_ON  = 4'h9;
	localparam logic [3:0] MIDI_NOTE_OFF = 4'h8;

	// Clamp limits and reset values of the registers.
	localparam logic [10:0] RATE_MAX    = 11'd2000;
	localparam logic [10:0] RATE_MIN    = 11'd1;
	localparam logic [15:0] DEPTH_MAX   = 16'd32768;
	localparam logic [10:0] RATE_RESET  = 11'd100;
	localparam logic [15:0] DEPTH_RESET = 16'd8192;
	localparam logic [17:0] SR_RESET    = 18'd44100;

	// Phase increment operands: rate*frames fits 24 bits, 100 times the sample rate fits 25 bits.
	localparam int NUM_W    = 24;
	localparam int DEN_W    = 25;
	localparam int SR_SCALE = 100;

	localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	// One quarter-wave entry from its angle x in Q30: Taylor series to x^11.
	function automatic logic [14:0] glfo_sine_entry(input logic [63:0] x);
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		logic [63:0] e;
		x2 = (x * x) >> 30;
		t  = Q30_ONE;
		t  = Q30_ONE - (((x2 * t) >> 30) / 64'd110);
		t  = Q30_ONE - (((x2 * t) >> 30) / 64'd72);
		t  = Q30_ONE - (((x2 * t) >> 30) / 64'd42);
		t  = Q30_ONE - (((x2 * t) >> 30) / 64'd20);
		t  = Q30_ONE - (((x2 * t) >> 30) / 64'd6);
		s  = (x * t) >> 30;
		e  = (s * 64'd32767 + (Q30_ONE >> 1)) >> 30;
		if (e > 64'd32767) begin
			e = 64'd32767;
		end
		return e[14:0];
	endfunction

endpackage

// ===== rtl/glfo_divider.sv =====
// Iterative restoring divider for the phase increment, one quotient bit a cycle.
// Returns the low PHASE_BITS bits of (numer << PHASE_BITS) / denom.
// Depends on glfo_pkg.
module glfo_divider #(
	parameter int PHASE_BITS = glfo_pkg::PHASE_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [glfo_pkg::NUM_W-1:0]  numer,
	input  logic [glfo_pkg::DEN_W-1:0]  denom,
	output logic                        done,
	output logic [PHASE_BITS-1:0]       quot
);
	import glfo_pkg::*;

	localparam int DVD_W = NUM_W + PHASE_BITS;
	localparam int STEPS = DVD_W;
	localparam int CNT_W = $clog2(STEPS);

	logic [DVD_W-1:0]      dvd_q;
	logic [DEN_W-1:0]      rem_q;
	logic [DEN_W-1:0]      den_q;
	logic [PHASE_BITS-1:0] quot_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q;
	logic                  done_q;

	logic [DEN_W:0]   trial;
	logic             ge;
	logic [DEN_W-1:0] rem_nx;

	assign trial  = {rem_q, dvd_q[DVD_W-1]};
	assign ge     = trial >= {1'b0, den_q};
	// The remainder stays below the divisor, so it fits the divisor width.
	assign rem_nx = ge ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= {numer, {PHASE_BITS{1'b0}}};
			den_q <= denom;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q  <= {dvd_q[DVD_W-2:0], 1'b0};
			rem_q  <= rem_nx;
			quot_q <= {quot_q[PHASE_BITS-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

// ===== rtl/glfo_wave.sv =====
// Waveform sample generator: sine from a quarter-wave ROM, triangle, square, saw.
// Registered in s1 on the strobe, then in value_s2; held until the next strobe.
// Depends on glfo_pkg.
module glfo_wave #(
	parameter int PHASE_BITS       = glfo_pkg::PHASE_BITS_DEF,
	parameter int SINE_TABLE_DEPTH = glfo_pkg::SINE_TABLE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  sample,
	input  logic [PHASE_BITS-1:0] phase,
	input  logic [1:0]            shape,
	output logic signed [15:0]    value
);
	import glfo_pkg::*;

	localparam int QS    = PHASE_BITS - 2;
	localparam int IDX_W = $clog2(SINE_TABLE_DEPTH + 1);
	localparam int PW    = QS + IDX_W;
	localparam logic [IDX_W-1:0] DEPTH_V = IDX_W'(SINE_TABLE_DEPTH);

	logic [14:0] sine_rom [SINE_TABLE_DEPTH+1];

	for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_rom
		localparam logic [63:0] XK =
			(64'(k) * HALF_PI_Q30 + SINE_TABLE_DEPTH / 2) / SINE_TABLE_DEPTH;
		localparam logic [14:0] ENTRY = glfo_sine_entry(XK);
		assign sine_rom[k] = ENTRY;
	end

	logic [1:0]            quad;
	logic [PW-1:0]         prod;
	logic [IDX_W-1:0]      idx_raw;
	logic [IDX_W-1:0]      idx;
	logic [PHASE_BITS-1:0] half;
	logic [PHASE_BITS-1:0] ph_dist;
	logic [PHASE_BITS+16:0] tri_wide;
	logic [16:0]           tri_t;
	logic [PHASE_BITS+15:0] saw_wide;
	logic [15:0]           saw_u;
	logic [15:0]           other;

	assign quad    = phase[PHASE_BITS-1:PHASE_BITS-2];
	assign prod    = PW'(phase[QS-1:0]) * PW'(SINE_TABLE_DEPTH);
	assign idx_raw = prod[PW-1:QS];
	// Odd quadrants run the quarter wave backward.
	assign idx     = quad[0] ? DEPTH_V - idx_raw : idx_raw;

	assign half     = {1'b1, {(PHASE_BITS-1){1'b0}}};
	assign ph_dist  = (phase >= half) ? phase - half : half - phase;
	assign tri_wide = {ph_dist, 17'b0} >> PHASE_BITS;
	assign tri_t    = tri_wide[16:0];
	assign saw_wide = {phase, 16'b0} >> PHASE_BITS;
	assign saw_u    = saw_wide[15:0];

	always_comb begin
		case (shape)
			SHAPE_TRI: begin
				// At the middle of the cycle the peak saturates to full scale.
				if (tri_t == 17'd0) begin
					other = 16'h7FFF;
				end else begin
					other = 16'(17'd32768 - tri_t);
				end
			end
			SHAPE_SQR: other = phase[PHASE_BITS-1] ? 16'h8000 : 16'h7FFF;
			SHAPE_SAW: other = {~saw_u[15], saw_u[14:0]};
			default:   other = 16'h0000;
		endcase
	end

	logic [IDX_W-1:0] idx_s1;
	logic             neg_s1;
	logic             sine_s1;
	logic [15:0]      other_s1;
	logic [15:0]      value_s2;

	always_ff @(posedge clk) begin
		if (sample) begin
			idx_s1   <= idx;
			neg_s1   <= quad[1];
			sine_s1  <= (shape == SHAPE_SIN);
			other_s1 <= other;
		end
		if (sine_s1) begin
			value_s2 <= neg_s1 ? 16'(-{1'b0, sine_rom[idx_s1]}) : {1'b0, sine_rom[idx_s1]};
		end else begin
			value_s2 <= other_s1;
		end
	end

	assign value = $signed(value_s2);

endmodule

// ===== rtl/gated_lfo_modulator.sv =====
// Gated LFO modulator top level: register file, note map, sequencer, output register.
// A MIDI word goes from the input latch through the execute and emit states to the
// output register; a tick with a value also waits in the divide state for the divider.
// One word at a time: in_ready is low until the sequencer is idle again; the next word
// is taken while a result waits in the output register.
// Reset (async, active low) restores defaults and clears phase, note map, count and flag.
module gated_lfo_modulator #(
	parameter int PHASE_BITS       = glfo_pkg::PHASE_BITS_DEF,
	parameter int SINE_TABLE_DEPTH = glfo_pkg::SINE_TABLE_DEPTH_DEF,
	parameter int NOTE_COUNT       = glfo_pkg::NOTE_COUNT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [2:0]                      cfg_index,
	input  logic [glfo_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            command,
	input  logic [7:0]                      status_byte,
	input  logic [7:0]                      first_data,
	input  logic [7:0]                      second_data,
	input  logic [1:0]                      msg_len,
	input  logic [12:0]                     tick_frames,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [1:0]                      result_kind,
	output logic [7:0]                      out_status,
	output logic [7:0]                      out_first,
	output logic [7:0]                      out_second,
	output logic [1:0]                      out_len,
	output logic signed [15:0]              lfo_value,
	output logic [15:0]                     sent_depth,
	output logic signed [15:0]              sent_offset,
	output logic                            sent_bipolar
);
	import glfo_pkg::*;

	localparam int NOTE_W = $clog2(NOTE_COUNT);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	// Configuration registers.
	logic [1:0]  wave_shape_q;
	logic [10:0] rate_q;
	logic [15:0] depth_q;
	logic [15:0] offset_q;
	logic        bipolar_q;
	logic        retrig_q;
	logic        enable_q;
	logic [17:0] sr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_shape_q <= SHAPE_SIN;
			rate_q       <= RATE_RESET;
			depth_q      <= DEPTH_RESET;
			offset_q     <= 16'd0;
			bipolar_q    <= 1'b1;
			retrig_q     <= 1'b0;
			enable_q     <= 1'b0;
			sr_q         <= SR_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WAVE_SHAPE:   wave_shape_q <= cfg_data[1:0];
				REG_RATE_CENTIHZ: rate_q       <= cfg_data[10:0];
				REG_DEPTH_LEVEL:  depth_q      <= cfg_data[15:0];
				REG_OFFSET_LEVEL: offset_q     <= cfg_data[15:0];
				REG_BIPOLAR_MODE: bipolar_q    <= cfg_data[0];
				REG_RETRIGGER:    retrig_q     <= cfg_data[0];
				REG_OUTPUT_EN:    enable_q     <= cfg_data[0];
				REG_SRATE_HZ:     sr_q         <= cfg_data[17:0];
				default: ;
			endcase
		end
	end

	// Latched input word.
	logic        cmd_q;
	logic [7:0]  status_q;
	logic [7:0]  d1_q;
	logic [7:0]  d2_q;
	logic [1:0]  len_q;
	logic [12:0] frames_q;

	logic [1:0]            state_q;
	logic [PHASE_BITS-1:0] phase_q;
	logic [NOTE_COUNT-1:0] held_q;
	logic [7:0]            held_total_q;
	logic                  mod_active_q;
	logic [1:0]            pend_kind_q;
	logic                  out_valid_q;

	assign in_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_q    <= command;
			status_q <= status_byte;
			d1_q     <= first_data;
			d2_q     <= second_data;
			len_q    <= msg_len;
			frames_q <= tick_frames;
		end
	end

	// Note tracking decode.
	logic [NOTE_W-1:0] note_idx;
	logic              note_ok;
	logic              note_on;
	logic              note_off;

	assign note_idx = d1_q[NOTE_W-1:0];
	assign note_ok  = (len_q == 2'd3) && (32'(d1_q) < NOTE_COUNT);
	assign note_on  = (status_q[7:4] == MIDI_NOTE_ON) && (d2_q != 8'd0);
	assign note_off = (status_q[7:4] == MIDI_NOTE_OFF) || (status_q[7:4] == MIDI_NOTE_ON);

	// Tick decode and divider operands.
	logic                  tick_skip;
	logic                  tick_go;
	logic [10:0]           rate_c;
	logic [15:0]           depth_c;
	logic [NUM_W-1:0]      numer;
	logic [DEN_W-1:0]      denom;
	logic                  div_done;
	logic [PHASE_BITS-1:0] div_quot;
	logic signed [15:0]    wave_value;

	assign tick_skip = (frames_q == 13'd0) || (sr_q == 18'd0);
	assign tick_go   = (state_q == ST_EXEC) && cmd_q && !tick_skip && enable_q;
	assign rate_c    = (rate_q < RATE_MIN) ? RATE_MIN : ((rate_q > RATE_MAX) ? RATE_MAX : rate_q);
	assign depth_c   = (depth_q > DEPTH_MAX) ? DEPTH_MAX : depth_q;
	assign numer     = NUM_W'(rate_c) * NUM_W'(frames_q);
	assign denom     = DEN_W'(sr_q) * DEN_W'(SR_SCALE);

	glfo_divider #(
		.PHASE_BITS(PHASE_BITS)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (tick_go),
		.numer (numer),
		.denom (denom),
		.done  (div_done),
		.quot  (div_quot)
	);

	// The sample is taken at the pre-advance phase, before the divider finishes.
	glfo_wave #(
		.PHASE_BITS      (PHASE_BITS),
		.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
	) u_wave (
		.clk   (clk),
		.sample(tick_go),
		.phase (phase_q),
		.shape (wave_shape_q),
		.value (wave_value)
	);

	logic emit_load;
	assign emit_load = (state_q == ST_EMIT) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			phase_q      <= '0;
			held_q       <= '0;
			held_total_q <= 8'd0;
			mod_active_q <= 1'b0;
			pend_kind_q  <= KIND_MIDI;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (!cmd_q) begin
						if (len_q == 2'd0) begin
							state_q <= ST_IDLE;
						end else begin
							if (status_q == MIDI_START || status_q == MIDI_STOP) begin
								phase_q <= '0;
							end
							if (status_q == MIDI_STOP) begin
								held_q       <= '0;
								held_total_q <= 8'd0;
							end
							if (note_ok) begin
								if (note_on) begin
									if (!held_q[note_idx]) begin
										if (retrig_q && held_total_q == 8'd0) begin
											phase_q <= '0;
										end
										held_q[note_idx] <= 1'b1;
										held_total_q     <= held_total_q + 8'd1;
									end
								end else if (note_off) begin
									if (held_q[note_idx]) begin
										held_q[note_idx] <= 1'b0;
										if (held_total_q != 8'd0) begin
											held_total_q <= held_total_q - 8'd1;
										end
									end
								end
							end
							pend_kind_q <= KIND_MIDI;
							state_q     <= ST_EMIT;
						end
					end else if (tick_skip) begin
						state_q <= ST_IDLE;
					end else if (!enable_q) begin
						// A disabled tick sends a single clear, then stays quiet.
						if (mod_active_q) begin
							mod_active_q <= 1'b0;
							pend_kind_q  <= KIND_CLEAR;
							state_q      <= ST_EMIT;
						end else begin
							state_q <= ST_IDLE;
						end
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						phase_q      <= phase_q + div_quot;
						mod_active_q <= 1'b1;
						pend_kind_q  <= KIND_VALUE;
						state_q      <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	logic [1:0]  kind_q;
	logic [7:0]  ostat_q;
	logic [7:0]  ofirst_q;
	logic [7:0]  osecond_q;
	logic [1:0]  olen_q;
	logic [15:0] olfo_q;
	logic [15:0] odepth_q;
	logic [15:0] ooffset_q;
	logic        obip_q;

	always_ff @(posedge clk) begin
		if (emit_load) begin
			kind_q    <= pend_kind_q;
			ostat_q   <= 8'd0;
			ofirst_q  <= 8'd0;
			osecond_q <= 8'd0;
			olen_q    <= 2'd0;
			olfo_q    <= 16'd0;
			odepth_q  <= 16'd0;
			ooffset_q <= 16'd0;
			obip_q    <= 1'b0;
			if (pend_kind_q == KIND_MIDI) begin
				ostat_q   <= status_q;
				ofirst_q  <= len_q[1] ? d1_q : 8'd0;
				osecond_q <= (len_q == 2'd3) ? d2_q : 8'd0;
				olen_q    <= len_q;
			end else if (pend_kind_q == KIND_VALUE) begin
				olfo_q    <= wave_value;
				odepth_q  <= depth_c;
				ooffset_q <= offset_q;
				obip_q    <= bipolar_q;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign result_kind  = kind_q;
	assign out_status   = ostat_q;
	assign out_first    = ofirst_q;
	assign out_second   = osecond_q;
	assign out_len      = olen_q;
	assign lfo_value    = $signed(olfo_q);
	assign sent_depth   = odepth_q;
	assign sent_offset  = $signed(ooffset_q);
	assign sent_bipolar = obip_q;

	// The note count always equals the number of held notes.
	a_held_count: assert property (@(posedge clk) disable iff (!arst_n)
		held_total_q == 8'($countones(held_q)))
		else $error("held note count disagrees with note map");

	// The divider only finishes while the sequencer waits for it.
	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider finished outside the divide state");

	// An accepted word always starts execution next.
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == ST_EXEC)
		else $error("accepted word did not start execution");

	// A pending result waits while the output register is still full.
	a_emit_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT && out_valid_q && !out_ready |=> state_q == ST_EMIT)
		else $error("result left the emit state while output was stalled");

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for gated_lfo_modulator: a short directed table, then random
// phases under changing register settings, every result checked against the table or a predictor.
// Depends on rtl/glfo_pkg.sv and rtl/gated_lfo_modulator.sv.
`timescale 1ns / 1ps

module testbench;
	import glfo_pkg::*;

	localparam int PHASE_W       = PHASE_BITS_DEF;
	localparam int SINE_DEPTH    = SINE_TABLE_DEPTH_DEF;
	localparam int NOTES         = NOTE_COUNT_DEF;
	localparam int SETTLE_CYCLES = 64;
	localparam int NUM_PHASES    = 14;
	localparam int PHASE_WORDS   = 125;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam logic [PHASE_W-1:0] PHASE_HALF = {1'b1, {(PHASE_W-1){1'b0}}};

	typedef struct {
		logic        command;
		logic [7:0]  status_byte;
		logic [7:0]  first_data;
		logic [7:0]  second_data;
		logic [1:0]  msg_len;
		logic [12:0] tick_frames;
	} lfo_word_t;

	typedef struct {
		logic [1:0]         kind;
		logic [7:0]         status;
		logic [7:0]         first;
		logic [7:0]         second;
		logic [1:0]         len;
		logic signed [15:0] value;
		logic [15:0]        depth;
		logic signed [15:0] offset;
		logic               bipolar;
	} lfo_result_t;

	typedef struct {
		bit          is_reg;
		logic [2:0]  reg_index;
		logic [17:0] reg_data;
		lfo_word_t   word;
		bit          typed;
		bit          typed_has;
		lfo_result_t typed_res;
	} stim_row_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        command = 1'b0;
	logic [7:0]  status_byte = '0;
	logic [7:0]  first_data = '0;
	logic [7:0]  second_data = '0;
	logic [1:0]  msg_len = '0;
	logic [12:0] tick_frames = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  result_kind;
	logic [7:0]  out_status;
	logic [7:0]  out_first;
	logic [7:0]  out_second;
	logic [1:0]  out_len;
	logic signed [15:0] lfo_value;
	logic [15:0] sent_depth;
	logic signed [15:0] sent_offset;
	logic        sent_bipolar;

	gated_lfo_modulator dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .status_byte(status_byte), .first_data(first_data),
		.second_data(second_data), .msg_len(msg_len), .tick_frames(tick_frames),
		.out_valid(out_valid), .out_ready(out_ready),
		.result_kind(result_kind), .out_status(out_status), .out_first(out_first),
		.out_second(out_second), .out_len(out_len), .lfo_value(lfo_value),
		.sent_depth(sent_depth), .sent_offset(sent_offset), .sent_bipolar(sent_bipolar)
	);

	// Predictor copies of the registers and of the oscillator state.
	logic [1:0]         r_wave;
	logic [10:0]        r_rate;
	logic [15:0]        r_depth;
	logic signed [15:0] r_offset;
	logic               r_bipolar;
	logic               r_retrig;
	logic               r_enable;
	logic [17:0]        r_srate;
	logic [PHASE_W-1:0] phase_acc;
	logic [NOTES-1:0]   notes_held;
	logic [7:0]         notes_count;
	logic               mod_on;
	logic [14:0]        quarter_sine [0:SINE_DEPTH];

	lfo_result_t pending_results [$];
	stim_row_t   stim_rows [$];
	lfo_result_t no_result;
	int          errors = 0;
	int          stall_left = 0;
	int unsigned cycle_count = 0;
	bit          sender_idle = 1'b1;
	bit          sink_idle = 1'b1;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Quarter-wave entry k: series for sin up to x^11 in Q30, evaluated innermost first.
	function automatic logic [14:0] sine_point(input int unsigned k);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		logic [63:0] e;
		int n;
		x  = (64'(k) * HALF_PI_Q30 + SINE_DEPTH / 2) / SINE_DEPTH;
		x2 = (x * x) >> 30;
		t  = Q30_ONE;
		for (n = 5; n >= 1; n--)
			t = Q30_ONE - ((x2 * t) >> 30) / 64'(2 * n * (2 * n + 1));
		s = (x * t) >> 30;
		e = (s * 64'd32767 + (Q30_ONE >> 1)) >> 30;
		if (e > 64'd32767)
			e = 64'd32767;
		return e[14:0];
	endfunction

	function automatic logic signed [15:0] wave_at(input logic [PHASE_W-1:0] p);
		int v;
		logic [PHASE_W-1:0] d;
		logic [63:0] idx;
		logic [1:0] q;
		case (r_wave)
			SHAPE_TRI: begin
				d = p[PHASE_W-1] ? p - PHASE_HALF : PHASE_HALF - p;
				v = 32768 - int'((64'(d) << 17) >> PHASE_W);
			end
			SHAPE_SQR: v = p[PHASE_W-1] ? -32768 : 32767;
			SHAPE_SAW: v = int'((64'(p) << 16) >> PHASE_W) - 32768;
			default: begin
				q   = p[PHASE_W-1 -: 2];
				idx = (64'(p[PHASE_W-3:0]) * SINE_DEPTH) >> (PHASE_W - 2);
				// The second and fourth quadrants read the table backwards.
				if (q[0])
					idx = SINE_DEPTH - idx;
				v = int'(quarter_sine[idx]);
				if (q[1])
					v = -v;
			end
		endcase
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return v[15:0];
	endfunction

	function automatic void lfo_predict(input lfo_word_t w, output bit has,
			output lfo_result_t r);
		logic [10:0] rate;
		logic [15:0] depth;
		logic [63:0] inc;
		r   = '{default: '0};
		has = 1'b0;
		if (w.command == 1'b0) begin
			if (w.msg_len == 2'd0)
				return;
			if (w.status_byte == MIDI_START || w.status_byte == MIDI_STOP)
				phase_acc = '0;
			if (w.status_byte == MIDI_STOP) begin
				notes_held  = '0;
				notes_count = '0;
			end
			if (w.msg_len == 2'd3 && w.first_data < NOTES) begin
				if (w.status_byte[7:4] == MIDI_NOTE_ON && w.second_data != 8'd0) begin
					if (!notes_held[w.first_data]) begin
						if (r_retrig && notes_count == 8'd0)
							phase_acc = '0;
						notes_held[w.first_data] = 1'b1;
						notes_count = notes_count + 8'd1;
					end
				end else if (w.status_byte[7:4] == MIDI_NOTE_OFF ||
						w.status_byte[7:4] == MIDI_NOTE_ON) begin
					if (notes_held[w.first_data]) begin
						notes_held[w.first_data] = 1'b0;
						if (notes_count != 8'd0)
							notes_count = notes_count - 8'd1;
					end
				end
			end
			has      = 1'b1;
			r.kind   = KIND_MIDI;
			r.status = w.status_byte;
			r.first  = (w.msg_len > 2'd1) ? w.first_data : 8'd0;
			r.second = (w.msg_len > 2'd2) ? w.second_data : 8'd0;
			r.len    = w.msg_len;
			return;
		end
		if (w.tick_frames == 13'd0 || r_srate == 18'd0)
			return;
		if (!r_enable) begin
			if (mod_on) begin
				mod_on = 1'b0;
				has    = 1'b1;
				r.kind = KIND_CLEAR;
			end
			return;
		end
		rate  = (r_rate < RATE_MIN) ? RATE_MIN : (r_rate > RATE_MAX) ? RATE_MAX : r_rate;
		depth = (r_depth > DEPTH_MAX) ? DEPTH_MAX : r_depth;
		// The sample is taken at the phase before this tick advances it.
		r.value   = wave_at(phase_acc);
		inc       = ((64'(rate) * w.tick_frames) << PHASE_W) / (64'(r_srate) * SR_SCALE);
		phase_acc = phase_acc + inc[PHASE_W-1:0];
		mod_on    = 1'b1;
		has       = 1'b1;
		r.kind    = KIND_VALUE;
		r.depth   = depth;
		r.offset  = r_offset;
		r.bipolar = r_bipolar;
	endfunction

	task automatic check_field(input string name, input logic signed [31:0] expv,
			input logic signed [31:0] actv);
		if (actv !== expv) begin
			$error("%s: expected %0d, got %0d", name, expv, actv);
			errors++;
		end
	endtask

	always @(posedge clk) begin : result_check
		lfo_result_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("result_kind: expected no word, got %0d", result_kind);
				errors++;
			end else begin
				e = pending_results.pop_front();
				check_field("result_kind", e.kind, result_kind);
				check_field("out_status", e.status, out_status);
				check_field("out_first", e.first, out_first);
				check_field("out_second", e.second, out_second);
				check_field("out_len", e.len, out_len);
				check_field("lfo_value", e.value, lfo_value);
				check_field("sent_depth", e.depth, sent_depth);
				check_field("sent_offset", e.offset, sent_offset);
				check_field("sent_bipolar", e.bipolar, sent_bipolar);
			end
		end
	end

	// Result side: random stall bursts while idling is allowed.
	always @(posedge clk) begin
		if (!sink_idle) begin
			out_ready  <= 1'b1;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			out_ready  <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 4) == 0) begin
			out_ready  <= 1'b0;
			stall_left <= $urandom_range(0, 6);
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [17:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
			REG_WAVE_SHAPE:   r_wave    = data[1:0];
			REG_RATE_CENTIHZ: r_rate    = data[10:0];
			REG_DEPTH_LEVEL:  r_depth   = data[15:0];
			REG_OFFSET_LEVEL: r_offset  = data[15:0];
			REG_BIPOLAR_MODE: r_bipolar = data[0];
			REG_RETRIGGER:    r_retrig  = data[0];
			REG_OUTPUT_EN:    r_enable  = data[0];
			REG_SRATE_HZ:     r_srate   = data[17:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Wait until every expected word is out, then long enough for a tick with no result.
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_word(input lfo_word_t w, input bit typed, input bit t_has,
			input lfo_result_t t_res);
		lfo_result_t r;
		bit has;
		if (sender_idle && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		command     <= w.command;
		status_byte <= w.status_byte;
		first_data  <= w.first_data;
		second_data <= w.second_data;
		msg_len     <= w.msg_len;
		tick_frames <= w.tick_frames;
		do
			@(posedge clk);
		while (in_ready !== 1'b1);
		lfo_predict(w, has, r);
		if (typed) begin
			has = t_has;
			r   = t_res;
		end
		if (has)
			pending_results.push_back(r);
	endtask

	task automatic add_reg(input logic [2:0] idx, input logic [17:0] data);
		stim_row_t row;
		row           = '{default: '0};
		row.is_reg    = 1'b1;
		row.reg_index = idx;
		row.reg_data  = data;
		stim_rows.push_back(row);
	endtask

	task automatic add_word(input lfo_word_t w, input bit typed, input bit has,
			input lfo_result_t r);
		stim_row_t row;
		row           = '{default: '0};
		row.word      = w;
		row.typed     = typed;
		row.typed_has = has;
		row.typed_res = r;
		stim_rows.push_back(row);
	endtask

	function automatic lfo_word_t make_random_word();
		lfo_word_t w;
		int pick;
		logic note_on;
		w.command     = 1'b0;
		w.status_byte = 8'($urandom);
		w.first_data  = 8'($urandom);
		w.second_data = 8'($urandom);
		w.msg_len     = 2'($urandom);
		w.tick_frames = 13'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 44) begin
			w.command = 1'b1;
			// Mostly modest frame counts; now and then none, or any 13-bit count.
			case ($urandom_range(0, 19))
				0: w.tick_frames = 13'd0;
				1: ;
				default: w.tick_frames = 13'($urandom_range(1, 4096));
			endcase
		end else if (pick < 88) begin
			note_on = 1'($urandom_range(0, 1));
			w.status_byte = {note_on ? MIDI_NOTE_ON : MIDI_NOTE_OFF, 4'($urandom)};
			// A small pool of notes keeps repeats and the all-released case frequent.
			w.first_data  = ($urandom_range(0, 9) == 0) ? 8'($urandom) :
				8'($urandom_range(60, 67));
			w.second_data = ($urandom_range(0, 5) == 0) ? 8'd0 : 8'($urandom_range(1, 127));
			w.msg_len     = 2'd3;
		end else if (pick < 94) begin
			w.status_byte = $urandom_range(0, 1) ? MIDI_START : MIDI_STOP;
			w.msg_len     = 2'($urandom_range(1, 3));
		end
		return w;
	endfunction

	task automatic set_random_regs(input int ph);
		logic [17:0] v;
		write_reg(REG_WAVE_SHAPE, {16'($urandom), 2'(ph % 4)});
		case ($urandom_range(0, 5))
			0: v = 18'd0;
			1: v = 18'd1;
			2: v = 18'd2000;
			3: v = 18'd2047;
			default: v = 18'($urandom_range(1, 2000));
		endcase
		write_reg(REG_RATE_CENTIHZ, {7'($urandom), v[10:0]});
		case ($urandom_range(0, 4))
			0: v = 18'd0;
			1: v = 18'd32768;
			2: v = 18'hFFFF;
			default: v = 18'($urandom);
		endcase
		write_reg(REG_DEPTH_LEVEL, {2'($urandom), v[15:0]});
		case ($urandom_range(0, 3))
			0: v = 18'h8000;
			1: v = 18'h7FFF;
			default: v = 18'($urandom);
		endcase
		write_reg(REG_OFFSET_LEVEL, {2'($urandom), v[15:0]});
		write_reg(REG_BIPOLAR_MODE, 18'($urandom));
		write_reg(REG_RETRIGGER, 18'($urandom));
		write_reg(REG_OUTPUT_EN, {17'($urandom), 1'($urandom_range(0, 4) != 0)});
		case ($urandom_range(0, 6))
			0: v = 18'd1;
			1: v = 18'd192000;
			2: v = 18'h3FFFF;
			3: v = 18'd44100;
			4: v = 18'($urandom_range(1, 1000));
			default: v = 18'($urandom);
		endcase
		write_reg(REG_SRATE_HZ, v);
	endtask

	initial begin : stimulus
		lfo_word_t w;
		bit prev_reg;
		int ph;
		int counted;

		no_result   = '{default: '0};
		r_wave      = SHAPE_SIN;
		r_rate      = RATE_RESET;
		r_depth     = DEPTH_RESET;
		r_offset    = '0;
		r_bipolar   = 1'b1;
		r_retrig    = 1'b0;
		r_enable    = 1'b0;
		r_srate     = SR_RESET;
		phase_acc   = '0;
		notes_held  = '0;
		notes_count = '0;
		mod_on      = 1'b0;
		for (int k = 0; k <= SINE_DEPTH; k++)
			quarter_sine[k] = sine_point(k);

		add_word('{1'b0, 8'h90, 8'h3C, 8'h64, 2'd3, 13'd0}, 1, 1,
			'{KIND_MIDI, 8'h90, 8'h3C, 8'h64, 2'd3, 16'sd0, 16'd0, 16'sd0, 1'b0});
		// A one-byte message drops both data bytes.
		add_word('{1'b0, 8'h80, 8'h3C, 8'h11, 2'd1, 13'd0}, 1, 1,
			'{KIND_MIDI, 8'h80, 8'h00, 8'h00, 2'd1, 16'sd0, 16'd0, 16'sd0, 1'b0});
		// An empty message and a disabled tick with nothing active give no word.
		add_word('{1'b0, 8'h90, 8'h22, 8'h33, 2'd0, 13'd0}, 1, 0, no_result);
		add_word('{1'b1, 8'h00, 8'h00, 8'h00, 2'd1, 13'd100}, 1, 0, no_result);
		add_reg(REG_OUTPUT_EN, 18'd1);
		add_word('{1'b1, 8'h00, 8'h00, 8'h00, 2'd0, 13'd1}, 1, 1,
			'{KIND_VALUE, 8'h00, 8'h00, 8'h00, 2'd0, 16'sd0, 16'd8192, 16'sd0, 1'b1});
		add_word('{1'b1, 8'hFF, 8'hFF, 8'hFF, 2'd3, 13'h1FFF}, 0, 0, no_result);
		add_word('{1'b0, 8'hFA, 8'h55, 8'hAA, 2'd1, 13'h1FFF}, 1, 1,
			'{KIND_MIDI, 8'hFA, 8'h00, 8'h00, 2'd1, 16'sd0, 16'd0, 16'sd0, 1'b0});
		add_word('{1'b1, 8'h00, 8'h00, 8'h00, 2'd0, 13'd0}, 1, 0, no_result);
		add_reg(REG_WAVE_SHAPE, 18'(SHAPE_TRI));
		add_word('{1'b1, 8'h00, 8'h00, 8'h00, 2'd0, 13'd1}, 1, 1,
			'{KIND_VALUE, 8'h00, 8'h00, 8'h00, 2'd0, 16'sh8000, 16'd8192, 16'sd0, 1'b1});
		add_reg(REG_WAVE_SHAPE, 18'(SHAPE_SAW));
		add_reg(REG_RATE_CENTIHZ, 18'd2047);
		add_reg(REG_DEPTH_LEVEL, 18'hFFFF);
		add_reg(REG_OFFSET_LEVEL, 18'h7FFF);
		add_reg(REG_BIPOLAR_MODE, 18'd0);
		add_reg(REG_SRATE_HZ, 18'd1);
		add_word('{1'b0, 8'hFC, 8'h12, 8'h34, 2'd2, 13'd0}, 1, 1,
			'{KIND_MIDI, 8'hFC, 8'h12, 8'h00, 2'd2, 16'sd0, 16'd0, 16'sd0, 1'b0});
		// Depth and rate above their limits are clamped.
		add_word('{1'b1, 8'h00, 8'h00, 8'h00, 2'd0, 13'd1}, 1, 1,
			'{KIND_VALUE, 8'h00, 8'h00, 8'h00, 2'd0, 16'sh8000, 16'h8000, 16'sh7FFF, 1'b0});
		add_word('{1'b1, 8'h00, 8'h00, 8'h00, 2'd0, 13'h1FFF}, 0, 0, no_result);
		add_reg(REG_RETRIGGER, 18'd1);
		add_reg(REG_WAVE_SHAPE, 18'(SHAPE_SQR));
		add_reg(REG_RATE_CENTIHZ, 18'd0);
		add_reg(REG_SRATE_HZ, 18'h3FFFF);
		add_reg(REG_OFFSET_LEVEL, 18'h8000);
		add_reg(REG_DEPTH_LEVEL, 18'd0);
		add_word('{1'b0, 8'h90, 8'h7F, 8'h01, 2'd3, 13'd0}, 0, 0, no_result);
		add_word('{1'b0, 8'h90, 8'h7F, 8'h40, 2'd3, 13'd0}, 0, 0, no_result);
		add_word('{1'b0, 8'h9F, 8'h80, 8'h40, 2'd3, 13'd0}, 0, 0, no_result);
		add_word('{1'b0, 8'h80, 8'h05, 8'h00, 2'd3, 13'd0}, 0, 0, no_result);
		add_word('{1'b0, 8'h90, 8'h05, 8'h00, 2'd3, 13'd0}, 0, 0, no_result);
		// The first held note pulled the phase back to zero.
		add_word('{1'b1, 8'h00, 8'h00, 8'h00, 2'd0, 13'd4096}, 1, 1,
			'{KIND_VALUE, 8'h00, 8'h00, 8'h00, 2'd0, 16'sh7FFF, 16'd0, 16'sh8000, 1'b0});
		add_reg(REG_OUTPUT_EN, 18'd0);
		add_word('{1'b1, 8'h00, 8'h00, 8'h00, 2'd0, 13'd5}, 1, 1,
			'{KIND_CLEAR, 8'h00, 8'h00, 8'h00, 2'd0, 16'sd0, 16'd0, 16'sd0, 1'b0});
		add_word('{1'b1, 8'h00, 8'h00, 8'h00, 2'd0, 13'd5}, 1, 0, no_result);
		add_reg(REG_SRATE_HZ, 18'd0);
		add_reg(REG_OUTPUT_EN, 18'd1);
		add_word('{1'b1, 8'h00, 8'h00, 8'h00, 2'd0, 13'd7}, 1, 0, no_result);
		add_reg(REG_SRATE_HZ, 18'd44100);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		prev_reg = 1'b0;
		foreach (stim_rows[i]) begin
			if (stim_rows[i].is_reg) begin
				if (!prev_reg)
					settle();
				write_reg(stim_rows[i].reg_index, stim_rows[i].reg_data);
				prev_reg = 1'b1;
			end else begin
				send_word(stim_rows[i].word, stim_rows[i].typed, stim_rows[i].typed_has,
					stim_rows[i].typed_res);
				prev_reg = 1'b0;
			end
		end

		for (ph = 0; ph < NUM_PHASES; ph++) begin
			// Some phases run without idling, and the last ones never idle.
			sender_idle = (ph < NUM_PHASES - 2) && (ph % 5 != 2);
			sink_idle   <= (ph < NUM_PHASES - 2) && (ph % 5 != 3);
			settle();
			set_random_regs(ph);
			counted = 0;
			while (counted < PHASE_WORDS) begin
				w = make_random_word();
				send_word(w, 1'b0, 1'b0, no_result);
				counted++;
			end
		end

		settle();
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
